/* hdl/lpht_pkg.sv */
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants of the linear probing hash table: word formats,
// operation and status codes and the stored entry layout.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int KEY_W          = 32;
  localparam int SLOT_W         = 4;
  localparam int TABLE_SIZE_DEF = 16;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_FIND   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    op_t              operation;
    logic [KEY_W-1:0] key;
  } in_word_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
  } out_word_t;

  // one table slot as kept in memory
  typedef struct packed {
    logic             used;
    logic [KEY_W-1:0] key;
  } entry_t;

endpackage

/* hdl/linear_probe_hash_table_core.sv */
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core
// Open addressed hash table with linear probing: insert or find of a 32-bit
// key, one probe per cycle through a single synchronous table memory.
// ----------------------------------------------------------------------------
// steps: accept, key modulo unit, first memory read, then P probes, P = probes taken (1..TABLE_SIZE)
// the key modulo unit gives the home slot, where the first memory read starts
// one word at a time: the next word is accepted once the result word is loaded
// the probe loop reads one slot per cycle; a result held by out_ready adds stall
// reset: a clearing pass empties every slot, in_ready low
module linear_probe_hash_table_core #(
  parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lpht_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lpht_pkg::out_word_t out_data
);
  import lpht_pkg::*;

  localparam int IDX_W   = $clog2(TABLE_SIZE);
  localparam int EXT_W   = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
  localparam int ENTRY_W = $bits(entry_t);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_SIZE - 1);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_HASH   = 6'b000100,
    S_LOOKUP = 6'b001000,
    S_PROBE  = 6'b010000,
    S_HOLD   = 6'b100000
  } state_t;

  state_t           state;
  op_t              op;
  logic [KEY_W-1:0] key;
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] pos_next;
  logic [IDX_W-1:0] probe_cnt;
  logic [IDX_W-1:0] clr_idx;
  out_word_t        res;

  logic             mod_start;
  logic             mod_done;
  logic [IDX_W-1:0] mod_rem;

  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [ENTRY_W-1:0] wdata;
  logic               re;
  logic [IDX_W-1:0]   raddr;
  logic [ENTRY_W-1:0] rdata;

  entry_t            entry;
  entry_t            new_entry;
  logic [EXT_W-1:0]  pos_ext;
  logic              probe_end;
  logic              ins_write;
  out_word_t         probe_res;
  logic              out_free;
  logic              out_load;

  assign in_ready  = (state == S_IDLE);
  assign mod_start = (state == S_IDLE) && in_valid;
  assign out_free  = !out_valid || out_ready;

  lpht_mod #(
    .TABLE_SIZE(TABLE_SIZE),
    .IDX_W     (IDX_W)
  ) u_mod (
    .clk  (clk),
    .rst  (rst),
    .start(mod_start),
    .key  (in_data.key),
    .done (mod_done),
    .rem  (mod_rem)
  );

  lpht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SIZE),
    .ADDR_W(IDX_W)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    entry    = entry_t'(rdata);
    pos_next = (pos == LAST) ? '0 : pos + 1'b1;
    pos_ext  = EXT_W'(pos);

    probe_end        = 1'b0;
    ins_write        = 1'b0;
    probe_res.status = ST_FULL;
    probe_res.slot   = '0;

    if (op == OP_INSERT) begin
      if (!entry.used) begin
        ins_write        = 1'b1;
        probe_end        = 1'b1;
        probe_res.status = ST_OK;
        probe_res.slot   = pos_ext[SLOT_W-1:0];
      end else if (probe_cnt == LAST) begin
        probe_end = 1'b1;
      end
    end else begin
      if (!entry.used) begin
        probe_end        = 1'b1;
        probe_res.status = ST_NOT_FOUND;
      end else if (entry.key == key) begin
        probe_end        = 1'b1;
        probe_res.status = ST_OK;
        probe_res.slot   = pos_ext[SLOT_W-1:0];
      end else if (probe_cnt == LAST) begin
        probe_end        = 1'b1;
        probe_res.status = ST_NOT_FOUND;
      end
    end

    // a new result word goes out this cycle
    out_load = (((state == S_PROBE) && probe_end) || (state == S_HOLD)) && out_free;

    new_entry.used = 1'b1;
    new_entry.key  = key;

    // clearing pass owns the write port until it finishes
    we    = (state == S_CLEAR) || ((state == S_PROBE) && ins_write);
    waddr = (state == S_CLEAR) ? clr_idx : pos;
    wdata = (state == S_CLEAR) ? '0 : ENTRY_W'(new_entry);

    // while probing, the next slot is read ahead
    re    = (state == S_LOOKUP) || (state == S_PROBE);
    raddr = (state == S_LOOKUP) ? pos : pos_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op    <= in_data.operation;
            key   <= in_data.key;
            state <= S_HASH;
          end
        end
        S_HASH: begin
          if (mod_done) begin
            pos       <= mod_rem;
            probe_cnt <= '0;
            state     <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          state <= S_PROBE;
        end
        S_PROBE: begin
          if (probe_end) begin
            if (out_free) begin
              out_valid <= 1'b1;
              out_data  <= probe_res;
              state     <= S_IDLE;
            end else begin
              res   <= probe_res;
              state <= S_HOLD;
            end
          end else begin
            pos       <= pos_next;
            probe_cnt <= probe_cnt + 1'b1;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_data  <= res;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

endmodule

/* hdl/lpht_ram.sv */
// ----------------------------------------------------------------------------
// lpht_ram
// Generic simple dual port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/lpht_mod.sv */
// ----------------------------------------------------------------------------
// lpht_mod
// Home slot unit: key modulo TABLE_SIZE, the quotient by reciprocal
// multiplication is registered, then the remainder by multiply back and
// subtract, with a one cycle done pulse when the remainder is ready.
// ----------------------------------------------------------------------------
module lpht_mod #(
  parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF,
  parameter int IDX_W = $clog2(TABLE_SIZE)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [lpht_pkg::KEY_W-1:0] key,
  output logic                      done,
  output logic [IDX_W-1:0]          rem
);
  import lpht_pkg::*;

  // ceil(2^(KEY_W+SHIFT) / TABLE_SIZE) gives the exact quotient for every key
  localparam int SHIFT   = $clog2(TABLE_SIZE);
  localparam int RECIP_W = KEY_W + 1;
  localparam int PROD_W  = KEY_W + RECIP_W;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << (KEY_W + SHIFT)) + 64'(TABLE_SIZE - 1)) / 64'(TABLE_SIZE);
  localparam logic [RECIP_W-1:0] RECIP   = RECIP_FULL[RECIP_W-1:0];
  localparam logic [KEY_W-1:0]   DIVISOR = KEY_W'(TABLE_SIZE);

  logic              busy;
  logic [KEY_W-1:0]  key_q;
  logic [KEY_W-1:0]  quo;
  logic [KEY_W-1:0]  quo_next;
  logic [PROD_W-1:0] prod;
  logic [KEY_W-1:0]  back;
  logic [KEY_W-1:0]  diff;
  logic [IDX_W-1:0]  rem_next;

  always_comb begin
    prod     = PROD_W'(key) * PROD_W'(RECIP);
    quo_next = KEY_W'(prod >> (KEY_W + SHIFT));
    back     = quo * DIVISOR;
    diff     = key_q - back;
    rem_next = diff[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= start;
      done <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      key_q <= key;
      quo   <= quo_next;
    end
    if (busy) begin
      rem <= rem_next;
    end
  end

endmodule

/* hdl/lpht_checker.sv */
// ----------------------------------------------------------------------------
// lpht_checker
// Port level checks of the hash table core, attached to it by a bind.
// ----------------------------------------------------------------------------
module lpht_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input lpht_pkg::in_word_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input lpht_pkg::out_word_t out_data
);
  import lpht_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // any failed operation reports slot zero
  a_fail_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != ST_OK) |-> (out_data.slot == '0))
    else $error("nonzero slot on failed operation");

  // reset starts the clearing pass with nothing pending
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("ready or result right after reset");

  // one word at a time: an accepted word closes the input side
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a word is in flight");

endmodule

bind linear_probe_hash_table_core lpht_checker u_checker (.*);
